### hdl/tphc_pkg.sv
// Shared types, constants and the stepper phase table for the printer head controller.
package tphc_pkg;

  localparam int unsigned MEDIA_WIDTH_BITS  = 12;
  localparam logic [MEDIA_WIDTH_BITS-1:0] MEDIA_WIDTH_RESET = 12'd800;
  localparam int unsigned COORD_BITS        = 16;
  localparam int unsigned DOT_BITS          = 7;
  localparam int unsigned WORD_BITS         = 16;
  localparam int unsigned READ_MODE_BIT     = 8;
  localparam int unsigned TOP_SHIFT_BIT     = 15;
  localparam int unsigned DOT_LSB           = 9;

  localparam logic [1:0] ACT_STATUS_READ = 2'd0;
  localparam logic [1:0] ACT_CTRL_WRITE  = 2'd1;
  localparam logic [1:0] ACT_PAPER_RESET = 2'd2;
  localparam logic [1:0] ACT_UNUSED      = 2'd3;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_COLUMN = 1'b1;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] write_value;
  } item_t;

  typedef struct packed {
    logic                         kind;
    logic [2:0]                   status;
    logic signed [COORD_BITS-1:0] column_x;
    logic signed [COORD_BITS-1:0] row_y;
    logic [DOT_BITS-1:0]          dot_pattern;
    logic                         last;
  } result_t;

  typedef struct packed {
    logic       known;
    logic [2:0] phase;
  } phase_t;

  // Control handed from the item stage to the result queue
  typedef struct packed {
    logic       load;
    logic [1:0] count;
  } queue_ctrl_t;

  // Phase of a four-coil drive pattern; patterns that mean nothing are not known
  function automatic phase_t phase_of(input logic [3:0] pattern);
    phase_t p;
    p.known = 1'b1;
    p.phase = 3'd0;
    case (pattern)
      4'h1: p.phase = 3'd0;
      4'h2: p.phase = 3'd2;
      4'h3: p.phase = 3'd1;
      4'h4: p.phase = 3'd4;
      4'h6: p.phase = 3'd3;
      4'h7: p.phase = 3'd2;
      4'h8: p.phase = 3'd6;
      4'h9: p.phase = 3'd7;
      4'hb: p.phase = 3'd0;
      4'hc: p.phase = 3'd5;
      4'hd: p.phase = 3'd6;
      4'he: p.phase = 3'd4;
      default: p.known = 1'b0;
    endcase
    return p;
  endfunction

endpackage

### hdl/tphc_stepper.sv
// Half-step stepper decode with saturating position update.
module tphc_stepper #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic signed [POSITION_BITS-1:0] pos,
  input  logic [3:0]                      pattern,
  output logic signed [POSITION_BITS-1:0] pos_next
);

  tphc_pkg::phase_t               ph;
  logic [2:0]                     cur;
  logic [2:0]                     nxt;
  logic [2:0]                     diff;
  logic signed [POSITION_BITS:0]  pos_w;
  logic signed [POSITION_BITS:0]  delta_w;
  logic signed [POSITION_BITS:0]  sum;

  always_comb begin
    ph      = tphc_pkg::phase_of(pattern);
    cur     = 3'd0 - pos[2:0];
    nxt     = ph.known ? ph.phase : cur;
    // signed three-bit distance, -4..+3
    diff    = nxt - cur;
    pos_w   = {pos[POSITION_BITS-1], pos};
    delta_w = {{(POSITION_BITS-2){diff[2]}}, diff};
    sum     = pos_w - delta_w;
    if (sum[POSITION_BITS] != sum[POSITION_BITS-1]) begin
      pos_next = sum[POSITION_BITS] ? {1'b1, {(POSITION_BITS-1){1'b0}}}
                                    : {1'b0, {(POSITION_BITS-1){1'b1}}};
    end else begin
      pos_next = sum[POSITION_BITS-1:0];
    end
  end

endmodule

### hdl/tphc_result_queue.sv
// Two-entry result queue; takes all results of one item at once.
module tphc_result_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  tphc_pkg::queue_ctrl_t ctrl,
  input  tphc_pkg::result_t     first,
  input  tphc_pkg::result_t     second,
  output logic                  can_load,
  output logic                  result_valid,
  input  logic                  result_ready,
  output tphc_pkg::result_t     result
);

  tphc_pkg::result_t entry [2];
  logic [1:0]        count;
  logic              pop;

  assign result_valid = (count != 2'd0);
  assign result       = entry[0];
  assign pop          = result_valid && result_ready;
  // a load always lands in an empty queue, possibly emptied this cycle
  assign can_load     = (count == 2'd0) || ((count == 2'd1) && result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (ctrl.load) begin
      count <= ctrl.count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      entry[0] <= first;
      entry[1] <= second;
    end else if (pop) begin
      entry[0] <= entry[1];
    end
  end

endmodule

### hdl/thermal_printer_head_controller.sv
// Top level of the printer head controller: item stage, head state and result queue.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------------------
//   item     | item_valid / item_ready    | item   (action, write_value)
//   result   | result_valid / result_ready| result (kind, status, column_x, ...)
//   cfg      | cfg_valid / cfg_ready      | cfg_data (paper width, 12 bits)
//
// An accepted item sits in the item register until the queue can take it; the head state and
// its results are settled from that register and the results move into a two-entry queue.
// Items with at most one result stream at one per cycle while result_ready holds; a write that
// prints two columns holds the next item until the single result port has taken one of them.
// Synchronous reset clears the head state and the queue and sets the paper
// width to 800. A stalled result side fills the queue and then holds the item
// stage, which in turn drops item_ready; cfg writes are always taken.
module thermal_printer_head_controller #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  tphc_pkg::item_t     item,
  output logic                result_valid,
  input  logic                result_ready,
  output tphc_pkg::result_t   result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [tphc_pkg::MEDIA_WIDTH_BITS-1:0] cfg_data
);

  // Item stage
  logic            stage_valid;
  tphc_pkg::item_t stage_item;
  logic            advance;
  logic            can_load;

  // Head state
  logic [tphc_pkg::MEDIA_WIDTH_BITS-1:0] media_width;
  logic                                  data_bit, data_bit_next;
  logic                                  shift_lvl, store_lvl;
  logic [tphc_pkg::WORD_BITS-1:0]        shift_word, shift_word_next;
  logic [tphc_pkg::WORD_BITS-1:0]        latch_word, latch_word_next;
  logic signed [POSITION_BITS-1:0]       head_pos, head_pos_next;
  logic signed [POSITION_BITS-1:0]       paper_pos, paper_pos_next;

  // Work of one control write
  logic                            wr_data, wr_shift, wr_store;
  logic                            read_mode;
  logic [tphc_pkg::WORD_BITS-1:0]  sw_shifted;
  logic [tphc_pkg::WORD_BITS-1:0]  latch_stored;
  logic                            d_shifted, d_stored;
  logic                            store_print, clear_print;
  logic signed [POSITION_BITS-1:0] head_stepped, paper_stepped;
  logic signed [POSITION_BITS-1:0] head_moved, paper_moved;
  logic                            on_paper;

  tphc_pkg::queue_ctrl_t qctrl;
  tphc_pkg::result_t     res_first, res_second, res_column, res_blank;

  assign cfg_ready  = 1'b1;
  assign advance    = stage_valid && can_load;
  assign item_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      stage_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      media_width <= tphc_pkg::MEDIA_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      media_width <= cfg_data;
    end
  end

  // Steppers see the freshly stored latch; a clear drives pattern zero and never moves
  tphc_stepper #(.POSITION_BITS(POSITION_BITS)) u_head_step (
    .pos      (head_pos),
    .pattern  (latch_stored[3:0]),
    .pos_next (head_stepped)
  );

  tphc_stepper #(.POSITION_BITS(POSITION_BITS)) u_paper_step (
    .pos      (paper_pos),
    .pattern  (latch_stored[7:4]),
    .pos_next (paper_stepped)
  );

  always_comb begin
    wr_data   = stage_item.write_value[0];
    wr_shift  = stage_item.write_value[1];
    wr_store  = stage_item.write_value[2];
    read_mode = latch_word[tphc_pkg::READ_MODE_BIT];

    // Rising shift clock: shift left, take in the data bit or show the top bit
    sw_shifted = shift_word;
    d_shifted  = wr_data;
    if (!shift_lvl && wr_shift) begin
      sw_shifted = {shift_word[tphc_pkg::WORD_BITS-2:0], 1'b0};
      if (read_mode) begin
        d_shifted = sw_shifted[tphc_pkg::TOP_SHIFT_BIT];
      end else begin
        sw_shifted[0] = wr_data;
      end
    end

    // Rising store clock outside read-back: copy the shift register into the latch
    store_print  = !store_lvl && wr_store && !read_mode;
    latch_stored = latch_word;
    d_stored     = d_shifted;
    if (store_print) begin
      latch_stored = sw_shifted;
      if (sw_shifted[tphc_pkg::READ_MODE_BIT]) begin
        d_stored = sw_shifted[tphc_pkg::TOP_SHIFT_BIT];
      end
    end

    // Store clock high in read-back: reload the shift register from the latch
    shift_word_next = sw_shifted;
    data_bit_next   = d_stored;
    if (wr_store && latch_stored[tphc_pkg::READ_MODE_BIT]) begin
      shift_word_next = latch_stored;
      data_bit_next   = latch_stored[tphc_pkg::TOP_SHIFT_BIT];
    end

    // Both clocks high: clear the latch
    clear_print     = wr_shift && wr_store;
    latch_word_next = clear_print ? '0 : latch_stored;

    head_moved  = store_print ? head_stepped  : head_pos;
    paper_moved = store_print ? paper_stepped : paper_pos;

    on_paper = !paper_moved[POSITION_BITS-1] && !head_moved[POSITION_BITS-1]
               && ($unsigned(head_moved) < POSITION_BITS'(media_width));
  end

  // Position register updates
  always_comb begin
    head_pos_next  = head_pos;
    paper_pos_next = paper_pos;
    case (stage_item.action)
      tphc_pkg::ACT_CTRL_WRITE: begin
        head_pos_next  = head_moved;
        paper_pos_next = paper_moved;
      end
      tphc_pkg::ACT_PAPER_RESET: begin
        paper_pos_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_bit   <= 1'b0;
      shift_lvl  <= 1'b0;
      store_lvl  <= 1'b0;
      shift_word <= '0;
      latch_word <= '0;
      head_pos   <= '0;
      paper_pos  <= '0;
    end else if (advance) begin
      if (stage_item.action == tphc_pkg::ACT_CTRL_WRITE) begin
        data_bit   <= data_bit_next;
        shift_lvl  <= wr_shift;
        store_lvl  <= wr_store;
        shift_word <= shift_word_next;
        latch_word <= latch_word_next;
      end
      head_pos  <= head_pos_next;
      paper_pos <= paper_pos_next;
    end
  end

  // Build the results of the item in the stage
  always_comb begin
    res_column.kind        = tphc_pkg::KIND_COLUMN;
    res_column.status      = 3'd0;
    res_column.column_x    = tphc_pkg::COORD_BITS'(head_moved);
    res_column.row_y       = tphc_pkg::COORD_BITS'(paper_moved);
    res_column.dot_pattern = latch_stored[tphc_pkg::DOT_LSB +: tphc_pkg::DOT_BITS];
    res_column.last        = 1'b0;
    res_blank              = res_column;
    res_blank.dot_pattern  = '0;

    qctrl.load  = advance;
    qctrl.count = 2'd0;
    res_first   = res_column;
    res_second  = res_blank;
    res_second.last = 1'b1;

    case (stage_item.action)
      tphc_pkg::ACT_STATUS_READ: begin
        qctrl.count           = 2'd1;
        res_first.kind        = tphc_pkg::KIND_STATUS;
        res_first.status      = {head_pos[POSITION_BITS-1], shift_lvl, data_bit};
        res_first.column_x    = '0;
        res_first.row_y       = '0;
        res_first.dot_pattern = '0;
        res_first.last        = 1'b1;
      end
      tphc_pkg::ACT_CTRL_WRITE: begin
        if (on_paper) begin
          if (store_print && clear_print) begin
            qctrl.count = 2'd2;
          end else if (store_print) begin
            qctrl.count    = 2'd1;
            res_first.last = 1'b1;
          end else if (clear_print) begin
            qctrl.count = 2'd1;
            res_first   = res_blank;
            res_first.last = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  tphc_result_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (qctrl),
    .first        (res_first),
    .second       (res_second),
    .can_load     (can_load),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

### tb/sv/tphc_result_checker.sv
// Result checker for the printer head controller: watches all three channels and predicts results.
module tphc_result_checker #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  input  logic                                  item_ready,
  input  tphc_pkg::item_t                       item,
  input  logic                                  result_valid,
  input  logic                                  result_ready,
  input  tphc_pkg::result_t                     result,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic [tphc_pkg::MEDIA_WIDTH_BITS-1:0] cfg_data,
  output int                                    fail_count,
  output int                                    pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tphc_pkg::*;

  localparam longint POS_LIM = longint'(1) << (POSITION_BITS - 1);

  logic                        data_bit;
  logic                        shift_level;
  logic                        store_level;
  logic [WORD_BITS-1:0]        shift_reg;
  logic [WORD_BITS-1:0]        latch_reg;
  logic [MEDIA_WIDTH_BITS-1:0] width_now;
  longint                      head_at;
  longint                      paper_at;

  result_t results_due[$];
  result_t fresh_results[$];

  // Phase taken up by a coil pattern; -1 where the pattern holds the motor still
  function automatic int coil_phase(input logic [3:0] coils);
    case (coils)
      4'h1, 4'hb: return 0;
      4'h3:       return 1;
      4'h2, 4'h7: return 2;
      4'h6:       return 3;
      4'h4, 4'he: return 4;
      4'hc:       return 5;
      4'h8, 4'hd: return 6;
      4'h9:       return 7;
      default:    return -1;
    endcase
  endfunction

  function automatic longint stepper_target(input longint at, input logic [3:0] coils);
    longint cur;
    longint nxt;
    longint delta;
    longint moved;
    cur = (-at) & 7;
    nxt = coil_phase(coils);
    if (nxt < 0) nxt = cur;
    delta = ((nxt - cur + 4) & 7) - 4;
    moved = at - delta;
    if (moved > POS_LIM - 1) moved = POS_LIM - 1;
    if (moved < -POS_LIM) moved = -POS_LIM;
    return moved;
  endfunction

  // In read-back mode the data line mirrors the top shift bit
  task automatic reload_data();
    if (latch_reg[READ_MODE_BIT]) data_bit = shift_reg[TOP_SHIFT_BIT];
  endtask

  task automatic latch_moved();
    result_t col;
    head_at  = stepper_target(head_at, latch_reg[3:0]);
    paper_at = stepper_target(paper_at, latch_reg[7:4]);
    if (paper_at < 0 || head_at < 0 || head_at >= longint'(width_now)) return;
    col             = '0;
    col.kind        = KIND_COLUMN;
    col.column_x    = COORD_BITS'(head_at);
    col.row_y       = COORD_BITS'(paper_at);
    col.dot_pattern = latch_reg[DOT_LSB +: DOT_BITS];
    fresh_results.push_back(col);
  endtask

  task automatic apply_access(input item_t acc);
    result_t rd;
    logic    new_shift;
    logic    new_store;
    fresh_results.delete();
    case (acc.action)
      ACT_STATUS_READ: begin
        rd        = '0;
        rd.kind   = KIND_STATUS;
        rd.status = {head_at < 0, shift_level, data_bit};
        fresh_results.push_back(rd);
      end
      ACT_PAPER_RESET: paper_at = 0;
      ACT_CTRL_WRITE: begin
        data_bit  = acc.write_value[0];
        new_shift = acc.write_value[1];
        new_store = acc.write_value[2];
        if (shift_level != new_shift) begin
          shift_level = new_shift;
          if (new_shift) begin
            shift_reg = shift_reg << 1;
            reload_data();
            if (!latch_reg[READ_MODE_BIT]) shift_reg[0] = data_bit;
          end
        end
        if (store_level != new_store) begin
          store_level = new_store;
          if (new_store && !latch_reg[READ_MODE_BIT]) begin
            latch_reg = shift_reg;
            reload_data();
            latch_moved();
          end
        end
        if (store_level && latch_reg[READ_MODE_BIT]) begin
          shift_reg = latch_reg;
          reload_data();
        end
        if (shift_level && store_level) begin
          latch_reg = '0;
          reload_data();
          latch_moved();
        end
      end
      default: ;
    endcase
    if (fresh_results.size() > 0) begin
      rd      = fresh_results.pop_back();
      rd.last = 1'b1;
      fresh_results.push_back(rd);
    end
    foreach (fresh_results[i]) results_due.push_back(fresh_results[i]);
  endtask

  function automatic bit field_ok(input string name, input logic signed [31:0] want,
                                  input logic signed [31:0] got);
    if (got === want) return 1'b1;
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    result_t want;
    bit      ok;
    if (rst) begin
      data_bit    = 1'b0;
      shift_level = 1'b0;
      store_level = 1'b0;
      shift_reg   = '0;
      latch_reg   = '0;
      head_at     = 0;
      paper_at    = 0;
      width_now   = MEDIA_WIDTH_RESET;
      fail_count  = 0;
      results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) width_now = cfg_data;
      if (result_valid && result_ready) begin
        if (results_due.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got kind %0d status %0d x %0d",
                   $time, result.kind, result.status, result.column_x,
                   " y %0d dots %0d last %0d", result.row_y, result.dot_pattern,
                   result.last);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          ok = field_ok("kind", want.kind, result.kind)
             & field_ok("status", want.status, result.status)
             & field_ok("column_x", want.column_x, result.column_x)
             & field_ok("row_y", want.row_y, result.row_y)
             & field_ok("dot_pattern", want.dot_pattern, result.dot_pattern)
             & field_ok("last", want.last, result.last);
          if (!ok) fail_count++;
        end
      end
      if (item_valid && item_ready) apply_access(item);
    end
    pending = results_due.size();
  end

endmodule

### tb/sv/tb_thermal_printer_head_controller.sv
// Testbench top: bit-banged bus stimulus, paper width writes and the pass/fail verdict.
module tb_thermal_printer_head_controller;
  timeunit 1ns;
  timeprecision 1ps;
  import tphc_pkg::*;

  localparam int unsigned POSITION_BITS    = 16;
  localparam int          PHASE_COUNT      = 6;
  localparam int          PHASE_ITEMS      = 225;
  // item register plus the two-entry queue, with room to spare
  localparam int          DRAIN_CYCLES     = 12;
  localparam int          LONG_HOLD_CYCLES = 300;

  logic                        clk          = 1'b0;
  logic                        rst          = 1'b1;
  logic                        item_valid   = 1'b0;
  logic                        item_ready;
  item_t                       item         = '0;
  logic                        result_valid;
  logic                        result_ready = 1'b0;
  result_t                     result;
  logic                        cfg_valid    = 1'b0;
  logic                        cfg_ready;
  logic [MEDIA_WIDTH_BITS-1:0] cfg_data     = '0;

  int fail_count;
  int pending;

  // Pacing knobs shared by the two driving processes
  bit tx_steady         = 1'b0;
  bit rx_steady         = 1'b0;
  int long_holds_asked  = 0;
  int long_holds_done   = 0;
  int accesses_sent     = 0;

  // Rough idea of where the motors stand, used only to steer the stimulus
  int       head_est    = 0;
  int       paper_est   = 0;
  int       head_goal   = 0;
  int       paper_goal  = 0;
  logic [2:0] head_phase  = 3'd0;
  logic [2:0] paper_phase = 3'd0;
  bit       latch_unsure = 1'b0;

  always #4 clk = ~clk;

  thermal_printer_head_controller #(
    .POSITION_BITS(POSITION_BITS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  tphc_result_checker #(
    .POSITION_BITS(POSITION_BITS)
  ) u_result_check (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  // Mostly short idle spans, now and then a long one
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(10, 40);
  endfunction

  // One coil pattern that puts the motor on the given phase
  function automatic logic [3:0] coils_for(input logic [2:0] ph);
    bit alt;
    alt = $urandom_range(0, 1);
    case (ph)
      3'd0:    return alt ? 4'hb : 4'h1;
      3'd1:    return 4'h3;
      3'd2:    return alt ? 4'h7 : 4'h2;
      3'd3:    return 4'h6;
      3'd4:    return alt ? 4'he : 4'h4;
      3'd5:    return 4'hc;
      3'd6:    return alt ? 4'hd : 4'h8;
      default: return 4'h9;
    endcase
  endfunction

  // Pick a position change of -3..+4 that heads towards the goal
  function automatic int pick_move(input int est, input int goal);
    int diff;
    diff = goal - est;
    if (diff == 0 || $urandom_range(0, 9) == 0) return int'($urandom_range(0, 7)) - 3;
    if (diff > 0) return $urandom_range(1, diff < 4 ? diff : 4);
    return -int'($urandom_range(1, -diff < 3 ? -diff : 3));
  endfunction

  // Offer one bus access; valid is held until the transfer, never dropped in between
  task automatic send_item(input logic [1:0] act, input logic [7:0] val);
    int gap;
    gap = tx_steady ? 0 : idle_span();
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{action: act, write_value: val};
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    if (act != ACT_UNUSED) accesses_sent++;
  endtask

  // Control write with random junk in the unused upper bits
  task automatic ctrl_write(input logic d, input logic sh, input logic st);
    send_item(ACT_CTRL_WRITE, {5'($urandom), st, sh, d});
  endtask

  task automatic shift_pulse(input logic d);
    ctrl_write(d, 1'b1, 1'b0);
    ctrl_write(1'($urandom), 1'b0, 1'b0);
  endtask

  task automatic store_pulse();
    ctrl_write(1'($urandom), 1'b0, 1'b1);
    ctrl_write(1'($urandom), 1'b0, 1'b0);
  endtask

  // Both clocks high: the latch clears and the motors see an idle pattern
  task automatic clear_pulse();
    ctrl_write(1'($urandom), 1'b1, 1'b1);
    ctrl_write(1'($urandom), 1'b0, 1'b0);
    latch_unsure = 1'b0;
  endtask

  task automatic status_read();
    send_item(ACT_STATUS_READ, 8'($urandom));
  endtask

  // Drop the item valid, let every expected result arrive, then let the block settle
  task automatic wait_idle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_paper_width(input logic [MEDIA_WIDTH_BITS-1:0] w);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Shift a whole latch word in and store it; head and paper step towards their goals
  task automatic load_latch(input logic read_mode);
    int         hm;
    int         pm;
    int         r;
    logic [3:0] hc;
    logic [3:0] pc;
    logic [6:0] dots;
    logic [15:0] word;
    if (latch_unsure) clear_pulse();
    if (head_est == head_goal) head_goal = int'($urandom_range(0, 46)) - 6;
    if (paper_est == paper_goal) paper_goal = int'($urandom_range(0, 26)) - 5;
    hm = pick_move(head_est, head_goal);
    pm = pick_move(paper_est, paper_goal);
    // now and then an idle pattern, which leaves the motor where it is
    if ($urandom_range(0, 11) == 0) begin
      hc = $urandom_range(0, 1) ? 4'h0 : ($urandom_range(0, 1) ? 4'h5 : 4'ha);
    end else begin
      head_phase = head_phase - 3'(hm);
      head_est   = head_est + hm;
      hc         = coils_for(head_phase);
    end
    if ($urandom_range(0, 11) == 0) begin
      pc = $urandom_range(0, 1) ? 4'hf : 4'h5;
    end else begin
      paper_phase = paper_phase - 3'(pm);
      paper_est   = paper_est + pm;
      pc          = coils_for(paper_phase);
    end
    r = $urandom_range(0, 9);
    dots = (r == 0) ? 7'h7f : (r == 1) ? 7'h00 : 7'($urandom);
    word = {dots, read_mode, pc, hc};
    for (int i = WORD_BITS - 1; i >= 0; i--) shift_pulse(word[i]);
    store_pulse();
  endtask

  // Enter read-back mode, clock the latched word out past the status port, then leave
  task automatic read_back_burst();
    int n;
    load_latch(1'b1);
    n = $urandom_range(2, 6);
    repeat (n) begin
      case ($urandom_range(0, 2))
        0:       status_read();
        1:       shift_pulse(1'($urandom));
        default: store_pulse();
      endcase
    end
    clear_pulse();
  endtask

  task automatic run_sequence();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      load_latch(1'b0);
    end else if (pick < 65) begin
      read_back_burst();
    end else if (pick < 73) begin
      clear_pulse();
    end else if (pick < 85) begin
      n = $urandom_range(1, 3);
      repeat (n) status_read();
    end else if (pick < 90) begin
      send_item(ACT_PAPER_RESET, 8'($urandom));
      paper_est   = 0;
      paper_phase = 3'd0;
    end else begin
      // noise: any action code, any byte, the unused code among them
      n = $urandom_range(1, 4);
      repeat (n) send_item(2'($urandom), 8'($urandom));
      latch_unsure = 1'b1;
    end
  endtask

  // Receiver: random stalls, and a long hold-off whenever one is asked for
  initial begin : result_side
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (long_holds_done != long_holds_asked) begin
        long_holds_done++;
        result_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
      end
      if (stall > 0) begin
        stall--;
        result_ready <= 1'b0;
      end else if (!rx_steady && $urandom_range(0, 99) < 25) begin
        stall = idle_span();
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    logic [MEDIA_WIDTH_BITS-1:0] widths [PHASE_COUNT];
    int target;
    int midway;
    bit paused;
    widths[0] = MEDIA_WIDTH_RESET;
    widths[1] = 12'd1;
    widths[2] = 12'd4095;
    widths[3] = 12'd0;
    widths[4] = 12'($urandom_range(2, 40));
    widths[5] = 12'd800;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed opening at the reset paper width
    status_read();
    ctrl_write(1'b0, 1'b0, 1'b0);
    send_item(ACT_CTRL_WRITE, 8'hf8);      // junk bits high, clocks low
    send_item(ACT_CTRL_WRITE, 8'h07);      // store edge then clear: two columns
    status_read();
    send_item(ACT_CTRL_WRITE, 8'h00);
    send_item(ACT_UNUSED, 8'hff);          // unused code, dropped
    send_item(ACT_UNUSED, 8'h06);
    send_item(ACT_PAPER_RESET, 8'hff);
    send_item(ACT_PAPER_RESET, 8'h00);
    send_item(ACT_STATUS_READ, 8'h00);
    send_item(ACT_CTRL_WRITE, 8'h03);      // shift edge with data high
    send_item(ACT_CTRL_WRITE, 8'hfc);      // store edge with shift falling
    send_item(ACT_STATUS_READ, 8'hff);
    send_item(ACT_CTRL_WRITE, 8'h06);      // clear from store already high
    send_item(ACT_CTRL_WRITE, 8'h00);

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      if (ph > 0) begin
        wait_idle();
        write_paper_width(widths[ph]);
      end
      head_goal = int'($urandom_range(0, 46)) - 6;
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      if (ph == 2) begin
        // hold the result side off while items keep coming, so the input stalls
        tx_steady = 1'b1;
        long_holds_asked++;
      end
      target = accesses_sent + PHASE_ITEMS;
      midway = accesses_sent + PHASE_ITEMS / 2;
      paused = 1'b0;
      while (accesses_sent < target) begin
        if (ph == 4 && !paused && accesses_sent >= midway) begin
          // pause the sender until every outstanding result has drained
          wait_idle();
          paused = 1'b1;
        end
        run_sequence();
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### sim.f
hdl/tphc_pkg.sv
hdl/tphc_stepper.sv
hdl/tphc_result_queue.sv
hdl/thermal_printer_head_controller.sv
tb/sv/tphc_result_checker.sv
tb/sv/tb_thermal_printer_head_controller.sv
